// File: rtl/mlpg_pkg.sv
// Shared constants, codes and channel entry type for the light pattern generator.
`default_nettype none

package mlpg_pkg;

    // Field widths
    localparam int CH_W    = 4;
    localparam int KIND_W  = 2;
    localparam int PAT_W   = 3;
    localparam int PER_W   = 15;
    localparam int STEP_W  = 8;
    localparam int TIME_W  = 32;
    localparam int CFG_W   = 15;
    localparam int CFG_IDX_W = 1;

    // Input beat kinds
    localparam logic [KIND_W-1:0] KIND_TICK    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SET_ONE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SET_ALL = 2'd2;

    // Pattern codes (6 and 7 are unused and leave a channel untouched)
    localparam logic [PAT_W-1:0] PAT_INIT    = 3'd0;
    localparam logic [PAT_W-1:0] PAT_OFF     = 3'd1;
    localparam logic [PAT_W-1:0] PAT_ON      = 3'd2;
    localparam logic [PAT_W-1:0] PAT_PULSE   = 3'd3;
    localparam logic [PAT_W-1:0] PAT_BREATHE = 3'd4;
    localparam logic [PAT_W-1:0] PAT_STROBE  = 3'd5;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_PERIOD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_STEP   = 1'b1;

    // Reset values
    localparam logic [PER_W-1:0]  RST_PERIOD = 15'd1000;
    localparam logic [STEP_W-1:0] RST_STEP   = 8'd1;

    // Per-channel entry, less the ramp value whose width follows the duty range
    typedef struct packed {
        logic [PAT_W-1:0]  pattern;
        logic              started;
        logic [TIME_W-1:0] start_ms;
        logic              light;
        logic [PER_W-1:0]  period;
        logic [STEP_W-1:0] step_extra;
    } mlpg_chan_t;

endpackage

`default_nettype wire

// File: rtl/mlpg_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module mlpg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, data held while re is low
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/mlpg_chan_upd.sv
// One millisecond step of a single channel's pattern, plus its drive outputs.
`default_nettype none

module mlpg_chan_upd
    import mlpg_pkg::*;
#(
    parameter int DUTY_MAX = 255,
    localparam int DUTY_W = $clog2(DUTY_MAX + 1),
    localparam int RAMP_W = $clog2(DUTY_MAX + 257) + 1
) (
    input  wire mlpg_chan_t               cur,
    input  wire logic signed [RAMP_W-1:0] cur_ramp,
    input  wire logic [TIME_W-1:0]        now_ms,
    input  wire logic [PER_W-1:0]         init_period,
    input  wire logic [STEP_W-1:0]        init_step,
    output mlpg_chan_t                    nxt,
    output logic signed [RAMP_W-1:0]      nxt_ramp,
    output logic                          pwm_mode,
    output logic                          level_on,
    output logic [DUTY_W-1:0]             duty
);

    localparam logic signed [RAMP_W-1:0] DMAX_S = RAMP_W'(DUTY_MAX);

    logic [TIME_W-1:0]        elapsed;
    logic                     due;
    logic signed [RAMP_W-1:0] step;
    logic                     dir_up;

    // Pattern step
    always_comb begin
        nxt      = cur;
        nxt_ramp = cur_ramp;
        elapsed  = now_ms - cur.start_ms;
        due      = cur.started && (elapsed > TIME_W'(cur.period));
        step     = RAMP_W'(cur.step_extra) + RAMP_W'(1);
        dir_up   = cur.light;
        unique case (cur.pattern)
            PAT_INIT: begin
                nxt.pattern    = PAT_OFF;
                nxt.started    = 1'b0;
                nxt.start_ms   = '0;
                nxt.light      = 1'b0;
                nxt_ramp       = '0;
                nxt.period     = init_period;
                nxt.step_extra = init_step;
            end
            PAT_OFF, PAT_ON: begin
                nxt.light   = (cur.pattern == PAT_ON);
                nxt.started = 1'b0;
            end
            PAT_PULSE, PAT_STROBE: begin
                if (!cur.started) begin
                    nxt.started  = 1'b1;
                    nxt.start_ms = now_ms;
                    nxt.light    = 1'b1;
                end else if (due) begin
                    if (cur.pattern == PAT_PULSE) begin
                        nxt.pattern = PAT_OFF;
                        nxt.started = 1'b0;
                        nxt.light   = 1'b0;
                    end else begin
                        nxt.start_ms = now_ms;
                        nxt.light    = !cur.light;
                    end
                end
            end
            PAT_BREATHE: begin
                if (!cur.started) begin
                    nxt.started  = 1'b1;
                    nxt.start_ms = now_ms;
                    nxt_ramp     = DMAX_S;
                end else if (due) begin
                    // turn around at either end, else keep direction
                    if (cur_ramp >= DMAX_S) begin
                        dir_up = 1'b0;
                    end else if (cur_ramp <= 0) begin
                        dir_up = 1'b1;
                    end
                    nxt.light    = dir_up;
                    nxt_ramp     = dir_up ? (cur_ramp + step) : (cur_ramp - step);
                    nxt.start_ms = now_ms;
                end
            end
            default: begin
                nxt = cur;
            end
        endcase
    end

    // Drive outputs, duty clamped to the legal range
    always_comb begin
        pwm_mode = (nxt.pattern == PAT_BREATHE);
        level_on = !pwm_mode && nxt.light;
        if (!pwm_mode || nxt_ramp < 0) begin
            duty = '0;
        end else if (nxt_ramp > DMAX_S) begin
            duty = DUTY_W'(DUTY_MAX);
        end else begin
            duty = nxt_ramp[DUTY_W-1:0];
        end
    end

endmodule

`default_nettype wire

// File: rtl/multichannel_led_pattern_generator.sv
// Multichannel light pattern generator: command decode, channel sweep and output register.
//
// Input channel (s_*): one beat is a tick (kind 0), a set-channel command (kind 1)
// or a set-all-patterns command (kind 2); kind 3 is accepted and dropped.
// Output channel (m_*): each tick yields CHANNELS beats, channel 0 first, with
// m_last on the final one. Commands yield no beats.
// Sweep: the channel state RAM is read one entry ahead while the current entry
// is updated and written back, so one channel retires per cycle when the
// receiver keeps up. After a tick is accepted, the first entry passes through the
// RAM read and the output register before m_valid rises. s_ready is high only between items.
// If m_ready is low the sweep holds with the next entry parked on the RAM
// read port and resumes when the output register frees.
// Configuration (cfg_*) is a plain write port taken any cycle cfg_wr_en is
// high; write it only while the block is idle.
// Reset (aresetn low at a clock edge) returns every channel to the init
// pattern with period 1000 and step extra 1, clears the millisecond counter
// and drops any pending output beat; per-entry valid bits stand in for the
// RAM contents, so no clearing pass is needed.
`default_nettype none

module multichannel_led_pattern_generator
    import mlpg_pkg::*;
#(
    parameter int CHANNELS = 16,
    parameter int DUTY_MAX = 255,
    localparam int DUTY_W = $clog2(DUTY_MAX + 1)
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // configuration
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_wdata,
    // input beats
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [KIND_W-1:0]    s_kind,
    input  wire logic [CH_W-1:0]      s_channel,
    input  wire logic [PAT_W-1:0]     s_pattern,
    input  wire logic [PER_W-1:0]     s_period_ms,
    input  wire logic [STEP_W-1:0]    s_step_extra,
    // result beats
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [CH_W-1:0]           m_out_channel,
    output logic                      m_pwm_mode,
    output logic                      m_level_on,
    output logic [DUTY_W-1:0]         m_duty,
    output logic                      m_last
);

    localparam int RAMP_W  = $clog2(DUTY_MAX + 257) + 1;
    localparam int IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int ENTRY_W = $bits(mlpg_chan_t) + RAMP_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CHANNELS - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_TICK,
        S_ALL,
        S_ONE
    } state_t;

    // Registers
    state_t              state_reg, state_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [TIME_W-1:0]   now_reg, now_next;
    logic [PAT_W-1:0]    cmd_pat_reg, cmd_pat_next;
    logic [PER_W-1:0]    cmd_per_reg, cmd_per_next;
    logic [STEP_W-1:0]   cmd_step_reg, cmd_step_next;
    logic [PER_W-1:0]    init_per_reg;
    logic [STEP_W-1:0]   init_step_reg;
    logic [CHANNELS-1:0] valid_reg;
    logic                rd_valid_reg;
    logic                m_valid_reg, m_valid_next;
    logic [CH_W-1:0]     m_ch_reg, m_ch_next;
    logic                m_pwm_reg, m_pwm_next;
    logic                m_lvl_reg, m_lvl_next;
    logic [DUTY_W-1:0]   m_duty_reg, m_duty_next;
    logic                m_last_reg, m_last_next;

    // RAM port signals
    logic               ram_we, ram_re;
    logic [IDX_W-1:0]   ram_raddr;
    logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

    // Entry as seen by the update logic
    mlpg_chan_t               rd_chan, upd_chan, mod_chan;
    logic signed [RAMP_W-1:0] rd_ramp, upd_ramp;
    logic                     upd_pwm, upd_lvl;
    logic [DUTY_W-1:0]        upd_duty;

    logic in_acc, out_free, is_last, ch_ok;
    logic [IDX_W-1:0] start_addr;

    mlpg_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(CHANNELS)
    ) u_state_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(idx_reg),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    mlpg_chan_upd #(
        .DUTY_MAX(DUTY_MAX)
    ) u_chan_upd (
        .cur        (rd_chan),
        .cur_ramp   (rd_ramp),
        .now_ms     (now_reg),
        .init_period(init_per_reg),
        .init_step  (init_step_reg),
        .nxt        (upd_chan),
        .nxt_ramp   (upd_ramp),
        .pwm_mode   (upd_pwm),
        .level_on   (upd_lvl),
        .duty       (upd_duty)
    );

    // Never-written entries read as their reset value
    always_comb begin
        if (rd_valid_reg) begin
            {rd_chan, rd_ramp} = ram_rdata;
        end else begin
            rd_chan.pattern    = PAT_INIT;
            rd_chan.started    = 1'b0;
            rd_chan.start_ms   = '0;
            rd_chan.light      = 1'b0;
            rd_chan.period     = RST_PERIOD;
            rd_chan.step_extra = RST_STEP;
            rd_ramp            = '0;
        end
    end

    assign s_ready    = (state_reg == S_IDLE);
    assign in_acc     = s_valid && s_ready;
    assign out_free   = !m_valid_reg || m_ready;
    assign is_last    = (idx_reg == LAST_IDX);
    assign ch_ok      = (32'(s_channel) < CHANNELS);
    assign start_addr = (s_kind == KIND_SET_ONE) ? IDX_W'(s_channel) : '0;

    // Command entry edits
    always_comb begin
        mod_chan = rd_chan;
        if (state_reg == S_ONE) begin
            mod_chan.pattern    = cmd_pat_reg;
            mod_chan.period     = cmd_per_reg;
            mod_chan.step_extra = cmd_step_reg;
            mod_chan.started    = 1'b0;
        end else begin
            mod_chan.pattern = cmd_pat_reg;
        end
    end

    // Sequencer
    always_comb begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        now_next      = now_reg;
        cmd_pat_next  = cmd_pat_reg;
        cmd_per_next  = cmd_per_reg;
        cmd_step_next = cmd_step_reg;
        ram_we        = 1'b0;
        ram_re        = 1'b0;
        ram_raddr     = idx_reg + IDX_W'(1);
        ram_wdata     = {mod_chan, rd_ramp};
        m_valid_next  = m_valid_reg && !m_ready;
        m_ch_next     = m_ch_reg;
        m_pwm_next    = m_pwm_reg;
        m_lvl_next    = m_lvl_reg;
        m_duty_next   = m_duty_reg;
        m_last_next   = m_last_reg;
        unique case (state_reg)
            S_IDLE: begin
                ram_raddr = start_addr;
                if (in_acc) begin
                    cmd_pat_next  = s_pattern;
                    cmd_per_next  = s_period_ms;
                    cmd_step_next = s_step_extra;
                    idx_next      = start_addr;
                    if (s_kind == KIND_TICK) begin
                        now_next   = now_reg + TIME_W'(1);
                        ram_re     = 1'b1;
                        state_next = S_TICK;
                    end else if (s_kind == KIND_SET_ALL) begin
                        ram_re     = 1'b1;
                        state_next = S_ALL;
                    end else if (s_kind == KIND_SET_ONE && ch_ok) begin
                        ram_re     = 1'b1;
                        state_next = S_ONE;
                    end
                end
            end
            S_TICK: begin
                ram_wdata = {upd_chan, upd_ramp};
                if (out_free) begin
                    ram_we       = 1'b1;
                    m_valid_next = 1'b1;
                    m_ch_next    = CH_W'(idx_reg);
                    m_pwm_next   = upd_pwm;
                    m_lvl_next   = upd_lvl;
                    m_duty_next  = upd_duty;
                    m_last_next  = is_last;
                    if (is_last) begin
                        state_next = S_IDLE;
                    end else begin
                        ram_re   = 1'b1;
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
            end
            S_ALL: begin
                ram_we = 1'b1;
                if (is_last) begin
                    state_next = S_IDLE;
                end else begin
                    ram_re   = 1'b1;
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            S_ONE: begin
                ram_we     = 1'b1;
                state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            idx_reg      <= '0;
            now_reg      <= '0;
            cmd_pat_reg  <= PAT_INIT;
            cmd_per_reg  <= '0;
            cmd_step_reg <= '0;
            m_valid_reg  <= 1'b0;
            m_ch_reg     <= '0;
            m_pwm_reg    <= 1'b0;
            m_lvl_reg    <= 1'b0;
            m_duty_reg   <= '0;
            m_last_reg   <= 1'b0;
        end else begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            now_reg      <= now_next;
            cmd_pat_reg  <= cmd_pat_next;
            cmd_per_reg  <= cmd_per_next;
            cmd_step_reg <= cmd_step_next;
            m_valid_reg  <= m_valid_next;
            m_ch_reg     <= m_ch_next;
            m_pwm_reg    <= m_pwm_next;
            m_lvl_reg    <= m_lvl_next;
            m_duty_reg   <= m_duty_next;
            m_last_reg   <= m_last_next;
        end
    end

    // Entry valid bits, sampled alongside the RAM read
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (ram_we) begin
                valid_reg[idx_reg] <= 1'b1;
            end
            if (ram_re) begin
                rd_valid_reg <= valid_reg[ram_raddr];
            end
        end
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            init_per_reg  <= RST_PERIOD;
            init_step_reg <= RST_STEP;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_INIT_PERIOD: init_per_reg  <= cfg_wdata[PER_W-1:0];
                CFG_INIT_STEP:   init_step_reg <= cfg_wdata[STEP_W-1:0];
                default: begin
                    init_per_reg <= init_per_reg;
                end
            endcase
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_out_channel = m_ch_reg;
    assign m_pwm_mode    = m_pwm_reg;
    assign m_level_on    = m_lvl_reg;
    assign m_duty        = m_duty_reg;
    assign m_last        = m_last_reg;

`ifndef SYNTHESIS
    // Read-ahead never targets the entry being written back
    a_no_rw_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        (ram_we && ram_re) |-> (ram_raddr != idx_reg))
        else $error("RAM read and write hit the same entry");

    // Millisecond counter moves only on an accepted tick
    a_now_on_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_TICK && $past(state_reg) == S_IDLE)
            |-> (now_reg == $past(now_reg) + TIME_W'(1)))
        else $error("tick sweep started without counter advance");

    // A result is loaded only by the tick sweep
    a_out_from_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !$past(m_valid_reg)) |-> ($past(state_reg) == S_TICK))
        else $error("result beat produced outside a tick");

    // The last beat of a sweep ends it
    a_last_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_TICK && out_free && is_last) |=> (state_reg == S_IDLE))
        else $error("tick sweep did not end after final channel");
`endif

endmodule

`default_nettype wire

// File: tb/testbench.sv
// Self-checking testbench for the multichannel light pattern generator.
`timescale 1ns / 1ps

module testbench
    import mlpg_pkg::*;
();

    localparam int CHANNELS = 16;
    localparam int DUTY_MAX = 255;
    localparam int DUTY_W   = 8;
    localparam int SETTLE_CYCLES = 40;   // covers the time a command keeps the block busy
    localparam int HOLD_CYCLES   = 300;

    // Codes the package leaves unnamed
    localparam logic [KIND_W-1:0] KIND_UNUSED  = 2'd3;
    localparam logic [PAT_W-1:0]  PAT_SPARE_LO = 3'd6;
    localparam logic [PAT_W-1:0]  PAT_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [CH_W-1:0]   chan;
        logic              pwm;
        logic              level;
        logic [DUTY_W-1:0] duty;
        logic              last;
    } drive_beat_t;

    // Channel pattern predictor plus the queue of drive beats still owed
    class drive_scoreboard;
        logic [PER_W-1:0]  init_period;
        logic [STEP_W-1:0] init_step;
        logic [31:0]       now_ms;
        logic [PAT_W-1:0]  pat      [CHANNELS];
        bit                started  [CHANNELS];
        logic [31:0]       start_ms [CHANNELS];
        bit                light    [CHANNELS];
        int                ramp     [CHANNELS];
        logic [PER_W-1:0]  period   [CHANNELS];
        logic [STEP_W-1:0] step_x   [CHANNELS];
        drive_beat_t       expected_drive_q[$];
        int                errors;

        function new();
            init_period = RST_PERIOD;
            init_step   = RST_STEP;
            now_ms      = '0;
            errors      = 0;
            for (int c = 0; c < CHANNELS; c++) begin
                pat[c]      = PAT_INIT;
                started[c]  = 1'b0;
                start_ms[c] = '0;
                light[c]    = 1'b0;
                ramp[c]     = 0;
                period[c]   = RST_PERIOD;
                step_x[c]   = RST_STEP;
            end
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            if (idx == CFG_INIT_PERIOD)
                init_period = data;
            else
                init_step = data[STEP_W-1:0];
        endfunction

        function int pending();
            return expected_drive_q.size();
        endfunction

        // One channel's update on a millisecond tick
        function void advance_channel(int c);
            logic [31:0] elapsed;
            bit          due;
            int          inc;
            elapsed = now_ms - start_ms[c];
            due     = started[c] && (elapsed > 32'(period[c]));
            inc     = 1 + int'(step_x[c]);
            case (pat[c])
                PAT_INIT: begin
                    pat[c]      = PAT_OFF;
                    started[c]  = 1'b0;
                    start_ms[c] = '0;
                    light[c]    = 1'b0;
                    ramp[c]     = 0;
                    period[c]   = init_period;
                    step_x[c]   = init_step;
                end
                PAT_ON, PAT_OFF: begin
                    light[c]   = (pat[c] == PAT_ON);
                    started[c] = 1'b0;
                end
                PAT_PULSE, PAT_STROBE: begin
                    if (!started[c]) begin
                        started[c]  = 1'b1;
                        start_ms[c] = now_ms;
                        light[c]    = 1'b1;
                    end else if (due) begin
                        if (pat[c] == PAT_PULSE) begin
                            pat[c]     = PAT_OFF;
                            started[c] = 1'b0;
                            light[c]   = 1'b0;
                        end else begin
                            start_ms[c] = now_ms;
                            light[c]    = !light[c];
                        end
                    end
                end
                PAT_BREATHE: begin
                    if (!started[c]) begin
                        started[c]  = 1'b1;
                        start_ms[c] = now_ms;
                        ramp[c]     = DUTY_MAX;
                    end else if (due) begin
                        // direction flips only at or past the ends
                        if (ramp[c] >= DUTY_MAX)
                            light[c] = 1'b0;
                        else if (ramp[c] <= 0)
                            light[c] = 1'b1;
                        ramp[c]     = light[c] ? ramp[c] + inc : ramp[c] - inc;
                        start_ms[c] = now_ms;
                    end
                end
                default: ;   // spare codes leave the channel alone
            endcase
        endfunction

        // Tick: sweep every channel and queue its drive beat
        function void predict_tick();
            drive_beat_t exp_beat;
            int          d;
            now_ms = now_ms + 32'd1;
            for (int c = 0; c < CHANNELS; c++) begin
                advance_channel(c);
                d = ramp[c];
                if (d < 0)
                    d = 0;
                if (d > DUTY_MAX)
                    d = DUTY_MAX;
                exp_beat.chan  = CH_W'(c);
                exp_beat.pwm   = (pat[c] == PAT_BREATHE);
                exp_beat.level = !exp_beat.pwm && light[c];
                exp_beat.duty  = exp_beat.pwm ? DUTY_W'(d) : '0;
                exp_beat.last  = (c == CHANNELS - 1);
                expected_drive_q.push_back(exp_beat);
            end
        endfunction

        function void note_beat(logic [KIND_W-1:0] kind, logic [CH_W-1:0] ch,
                                logic [PAT_W-1:0] p, logic [PER_W-1:0] per,
                                logic [STEP_W-1:0] stp);
            if (kind == KIND_SET_ONE) begin
                pat[ch]     = p;
                period[ch]  = per;
                step_x[ch]  = stp;
                started[ch] = 1'b0;
            end else if (kind == KIND_SET_ALL) begin
                for (int c = 0; c < CHANNELS; c++)
                    pat[c] = p;
            end else if (kind == KIND_TICK) begin
                predict_tick();
            end
        endfunction

        task report_mismatch(string msg);
            errors++;
            if (errors <= 40)
                $display("%0t mismatch: %s", $realtime, msg);
        endtask

        task check_drive(drive_beat_t got);
            drive_beat_t want;
            if (expected_drive_q.size() == 0) begin
                report_mismatch($sformatf("unexpected beat for ch %0d", got.chan));
            end else begin
                want = expected_drive_q.pop_front();
                if (got !== want)
                    report_mismatch($sformatf(
                        "got %0d/%0b/%0b/%0d/%0b want %0d/%0b/%0b/%0d/%0b",
                        got.chan, got.pwm, got.level, got.duty, got.last,
                        want.chan, want.pwm, want.level, want.duty, want.last));
            end
        endtask
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;
    logic                 s_valid;
    logic                 s_ready;
    logic [KIND_W-1:0]    s_kind;
    logic [CH_W-1:0]      s_channel;
    logic [PAT_W-1:0]     s_pattern;
    logic [PER_W-1:0]     s_period_ms;
    logic [STEP_W-1:0]    s_step_extra;
    logic                 m_valid;
    logic                 m_ready;
    logic [CH_W-1:0]      m_out_channel;
    logic                 m_pwm_mode;
    logic                 m_level_on;
    logic [DUTY_W-1:0]    m_duty;
    logic                 m_last;

    drive_scoreboard sb;
    bit tx_calm;
    bit rx_calm;
    bit rx_hold_req;
    int rx_stall_left;
    int rx_gap;

    multichannel_led_pattern_generator #(
        .CHANNELS(CHANNELS),
        .DUTY_MAX(DUTY_MAX)
    ) u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_kind       (s_kind),
        .s_channel    (s_channel),
        .s_pattern    (s_pattern),
        .s_period_ms  (s_period_ms),
        .s_step_extra (s_step_extra),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_channel(m_out_channel),
        .m_pwm_mode   (m_pwm_mode),
        .m_level_on   (m_level_on),
        .m_duty       (m_duty),
        .m_last       (m_last)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    function automatic logic [CH_W-1:0] pick_channel();
        return CH_W'($urandom_range(0, CHANNELS - 1));
    endfunction

    // Mostly live patterns, some init and spare codes
    function automatic logic [PAT_W-1:0] pick_pattern();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85)
            return PAT_W'($urandom_range(PAT_OFF, PAT_STROBE));
        if (r < 93)
            return PAT_INIT;
        return PAT_W'($urandom_range(PAT_SPARE_LO, PAT_SPARE_HI));
    endfunction

    // Short periods so timers expire within the run, a few long ones
    function automatic logic [PER_W-1:0] pick_period();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return PER_W'($urandom_range(0, 3));
        if (r < 85)
            return PER_W'($urandom_range(4, 20));
        if (r < 95)
            return PER_W'($urandom_range(0, 300));
        return PER_W'($urandom_range(0, 32767));
    endfunction

    function automatic logic [STEP_W-1:0] pick_step();
        return STEP_W'($urandom_range(0, 254));
    endfunction

    // Offer one input beat and wait for its handshake
    task automatic send_beat(input logic [KIND_W-1:0] kind, input logic [CH_W-1:0] ch,
                             input logic [PAT_W-1:0] p, input logic [PER_W-1:0] per,
                             input logic [STEP_W-1:0] stp);
        int g;
        g = tx_calm ? 0 : gap_len();
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_kind       <= kind;
        s_channel    <= ch;
        s_pattern    <= p;
        s_period_ms  <= per;
        s_step_extra <= stp;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        sb.note_beat(kind, ch, p, per, stp);
    endtask

    // Tick fields other than kind carry junk the block must ignore
    task automatic send_tick();
        send_beat(KIND_TICK, pick_channel(), pick_pattern(), pick_period(), pick_step());
    endtask

    task automatic send_ticks(input int n);
        for (int i = 0; i < n; i++)
            send_tick();
    endtask

    // Drain every owed drive beat, then let a trailing command settle
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Write both init registers on consecutive cycles
    task automatic set_init_regs(input logic [PER_W-1:0] per, input logic [STEP_W-1:0] stp);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_INIT_PERIOD;
        cfg_wdata <= per;
        @(posedge aclk);
        sb.write_reg(CFG_INIT_PERIOD, per);
        cfg_index <= CFG_INIT_STEP;
        cfg_wdata <= CFG_W'(stp);
        @(posedge aclk);
        sb.write_reg(CFG_INIT_STEP, CFG_W'(stp));
        cfg_wr_en <= 1'b0;
    endtask

    // Mostly program-then-tick sequences, with some noise mixed in
    task automatic run_random(input int n);
        int sent;
        int r;
        int reps;
        sent = 0;
        while (sent < n) begin
            r = $urandom_range(0, 99);
            if ($urandom_range(0, 7) == 0)
                tx_calm = !tx_calm;
            if (r < 55) begin
                reps = $urandom_range(1, 3);
                for (int i = 0; i < reps; i++)
                    send_beat(KIND_SET_ONE, pick_channel(), pick_pattern(), pick_period(),
                              pick_step());
                sent += reps;
                reps = $urandom_range(2, 8);
                send_ticks(reps);
                sent += reps;
            end else if (r < 80) begin
                reps = $urandom_range(1, 4);
                send_ticks(reps);
                sent += reps;
            end else if (r < 88) begin
                send_beat(KIND_SET_ALL, pick_channel(), pick_pattern(), pick_period(),
                          pick_step());
                reps = $urandom_range(1, 3);
                send_ticks(reps);
                sent += 1 + reps;
            end else if (r < 94) begin
                send_beat(KIND_UNUSED, pick_channel(), PAT_W'($urandom_range(0, 7)),
                          PER_W'($urandom_range(0, 32767)), pick_step());
            end else begin
                send_beat(KIND_SET_ONE, pick_channel(), PAT_W'($urandom_range(0, 7)),
                          PER_W'($urandom_range(0, 32767)), pick_step());
                sent++;
            end
        end
    endtask

    // Result side: check accepted beats, stall at random, long hold on request
    initial begin
        rx_stall_left = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                sb.check_drive({m_out_channel, m_pwm_mode, m_level_on, m_duty, m_last});
                if ($urandom_range(0, 47) == 0)
                    rx_calm = !rx_calm;
            end
            if (rx_hold_req) begin
                rx_hold_req   = 1'b0;
                rx_stall_left = HOLD_CYCLES;
            end
            if (rx_stall_left > 0) begin
                m_ready <= 1'b0;
                rx_stall_left--;
            end else if (m_valid && m_ready && !rx_calm) begin
                rx_gap = gap_len();
                if (rx_gap > 0) begin
                    m_ready       <= 1'b0;
                    rx_stall_left = rx_gap - 1;
                end else begin
                    m_ready <= 1'b1;
                end
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog
    initial begin
        #12_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Stimulus
    initial begin
        sb           = new();
        tx_calm      = 1'b0;
        rx_calm      = 1'b0;
        rx_hold_req  = 1'b0;
        aresetn      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_index    = CFG_INIT_PERIOD;
        cfg_wdata    = '0;
        s_valid      = 1'b0;
        s_kind       = KIND_TICK;
        s_channel    = '0;
        s_pattern    = PAT_INIT;
        s_period_ms  = '0;
        s_step_extra = '0;
        m_ready      = 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: first tick runs init with the reset register values
        send_tick();
        send_beat(KIND_SET_ONE, 4'd0, PAT_ON, 15'd0, 8'd0);
        send_beat(KIND_SET_ONE, 4'd1, PAT_PULSE, 15'd1, 8'd0);
        send_beat(KIND_SET_ONE, 4'd2, PAT_STROBE, 15'd0, 8'd0);
        send_beat(KIND_SET_ONE, 4'd3, PAT_BREATHE, 15'd0, 8'd254);
        // steps 200 and 101 both run the ramp past zero before turning
        send_beat(KIND_SET_ONE, 4'd4, PAT_BREATHE, 15'd0, 8'd199);
        send_beat(KIND_SET_ONE, 4'd5, PAT_BREATHE, 15'd0, 8'd100);
        send_beat(KIND_SET_ONE, 4'd6, PAT_SPARE_LO, 15'd32767, 8'd0);
        send_beat(KIND_SET_ONE, 4'd7, PAT_SPARE_HI, 15'd0, 8'd254);
        send_beat(KIND_SET_ONE, 4'd8, PAT_INIT, 15'd5, 8'd3);
        send_beat(KIND_SET_ONE, 4'd15, PAT_PULSE, 15'd32767, 8'd254);
        send_beat(KIND_UNUSED, 4'd15, PAT_SPARE_HI, 15'd32767, 8'd254);
        send_ticks(7);
        send_beat(KIND_SET_ALL, 4'd0, PAT_STROBE, 15'd0, 8'd0);
        send_ticks(2);
        send_beat(KIND_SET_ALL, 4'd0, PAT_INIT, 15'd0, 8'd0);
        send_tick();
        wait_idle();

        // Phase 1: smallest init period, init step of 254
        set_init_regs(15'd0, 8'd254);
        send_beat(KIND_SET_ALL, 4'd0, PAT_INIT, 15'd0, 8'd0);
        send_tick();
        run_random(110);
        wait_idle();

        // Phase 2: largest init period, smallest step, with a long result hold-off
        set_init_regs(15'd32767, 8'd0);
        send_beat(KIND_SET_ALL, 4'd0, PAT_INIT, 15'd0, 8'd0);
        tx_calm     = 1'b1;
        rx_hold_req = 1'b1;
        send_ticks(12);
        tx_calm = 1'b0;
        run_random(110);
        wait_idle();

        // Phase 3: random init settings
        set_init_regs(PER_W'($urandom_range(0, 8)), pick_step());
        send_beat(KIND_SET_ALL, 4'd0, PAT_INIT, 15'd0, 8'd0);
        send_tick();
        run_random(110);
        s_valid <= 1'b0;

        // Drain with a bound, then a quiet stretch for stray beats
        for (int i = 0; i < 20000 && sb.pending() != 0; i++)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d drive beats never arrived", sb.pending()));

        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: filelist.f
rtl/mlpg_pkg.sv
rtl/mlpg_ram.sv
rtl/mlpg_chan_upd.sv
rtl/multichannel_led_pattern_generator.sv
tb/testbench.sv
